@@ src/dual_coil_brake_controller_assert.svh @@
// Assertion macros shared by the brake controller RTL.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef DUAL_COIL_BRAKE_CONTROLLER_ASSERT_SVH
`define DUAL_COIL_BRAKE_CONTROLLER_ASSERT_SVH

// Condition that must hold at every edge out of reset
`define DCBC_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// Same-cycle implication
`define DCBC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define DCBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/dcbc_pkg.sv @@
// Types and constants for the dual-coil brake controller.
// No dependencies.
package dcbc_pkg;

   localparam logic [2:0] CMD_INIT        = 3'd0;
   localparam logic [2:0] CMD_ENGAGE      = 3'd1;
   localparam logic [2:0] CMD_RELEASE     = 3'd2;
   localparam logic [2:0] CMD_UPDATE      = 3'd3;
   localparam logic [2:0] CMD_MAN_ENGAGE  = 3'd4;
   localparam logic [2:0] CMD_MAN_RELEASE = 3'd5;
   localparam logic [2:0] CMD_MAN_STOP    = 3'd6;

   localparam logic [1:0] ST_ENGAGED   = 2'd0;
   localparam logic [1:0] ST_ENGAGING  = 2'd1;
   localparam logic [1:0] ST_RELEASED  = 2'd2;
   localparam logic [1:0] ST_RELEASING = 2'd3;

   localparam logic [7:0] DEAD_TIME_RESET = 8'd10;

   // result queue entries; pointers wrap naturally, so keep a power of two
   localparam int RSLT_DEPTH = 4;

   typedef struct packed {
      logic [1:0] mode;
      logic       manual;
      logic       apply_coil;
      logic       release_coil;
   } ctrl_state_type;

   typedef struct packed {
      logic       last;
      logic [7:0] hold_time;
      logic       manual_mode;
      logic [1:0] brake_state;
      logic       release_coil;
      logic       apply_coil;
   } rslt_type;

endpackage

@@ src/dcbc_core.sv @@
// Command decode and next-state logic for the brake controller.
// Depends on dcbc_pkg.
module dcbc_core (
   input  logic [2:0]               cmd,
   input  logic                     limit_switch,
   input  logic [7:0]               dead_time,
   input  dcbc_pkg::ctrl_state_type cur,
   output dcbc_pkg::ctrl_state_type nxt,
   output dcbc_pkg::rslt_type       rslt_a,
   output dcbc_pkg::rslt_type       rslt_b,
   output logic [1:0]               rslt_num
);

   dcbc_pkg::rslt_type dead_rslt;
   dcbc_pkg::rslt_type fin_rslt;
   logic [1:0]         upd_mode;
   logic               upd_rel;

   // both coils off, shows the state from before the transaction
   always_comb begin
      dead_rslt.apply_coil   = 1'b0;
      dead_rslt.release_coil = 1'b0;
      dead_rslt.brake_state  = cur.mode;
      dead_rslt.manual_mode  = cur.manual;
      dead_rslt.hold_time    = dead_time;
      dead_rslt.last         = 1'b0;
   end

   always_comb begin
      upd_mode = cur.mode;
      upd_rel  = cur.release_coil;
      if (upd_mode == dcbc_pkg::ST_ENGAGING && limit_switch) begin
         upd_mode = dcbc_pkg::ST_ENGAGED;
      end
      if (upd_mode == dcbc_pkg::ST_RELEASING && !limit_switch) begin
         upd_mode = dcbc_pkg::ST_RELEASED;
         upd_rel  = 1'b0;
      end
      // switch contradicts a released brake
      if (upd_mode == dcbc_pkg::ST_RELEASED && limit_switch) begin
         upd_mode = dcbc_pkg::ST_ENGAGED;
      end
   end

   always_comb begin
      nxt      = cur;
      rslt_num = 2'd0;
      unique case (cmd)
         dcbc_pkg::CMD_INIT: begin
            nxt.apply_coil   = 1'b1;
            nxt.release_coil = 1'b0;
            nxt.mode = limit_switch ? dcbc_pkg::ST_ENGAGED : dcbc_pkg::ST_ENGAGING;
            rslt_num = 2'd1;
         end
         dcbc_pkg::CMD_ENGAGE: begin
            if (cur.mode == dcbc_pkg::ST_RELEASED || cur.mode == dcbc_pkg::ST_RELEASING) begin
               nxt.apply_coil   = 1'b1;
               nxt.release_coil = 1'b0;
               nxt.mode         = dcbc_pkg::ST_ENGAGING;
               rslt_num         = 2'd2;
            end
         end
         dcbc_pkg::CMD_RELEASE: begin
            if (cur.mode == dcbc_pkg::ST_ENGAGED || cur.mode == dcbc_pkg::ST_ENGAGING) begin
               nxt.apply_coil   = 1'b0;
               nxt.release_coil = 1'b1;
               nxt.mode         = dcbc_pkg::ST_RELEASING;
               rslt_num         = 2'd2;
            end
         end
         dcbc_pkg::CMD_UPDATE: begin
            if (!cur.manual) begin
               nxt.mode         = upd_mode;
               nxt.release_coil = upd_rel;
               rslt_num         = 2'd1;
            end
         end
         dcbc_pkg::CMD_MAN_ENGAGE: begin
            nxt.manual       = 1'b1;
            nxt.apply_coil   = 1'b1;
            nxt.release_coil = 1'b0;
            rslt_num         = 2'd1;
         end
         dcbc_pkg::CMD_MAN_RELEASE: begin
            nxt.manual       = 1'b1;
            nxt.apply_coil   = 1'b0;
            nxt.release_coil = 1'b1;
            rslt_num         = 2'd1;
         end
         dcbc_pkg::CMD_MAN_STOP: begin
            if (cur.manual) begin
               nxt.manual       = 1'b0;
               nxt.apply_coil   = 1'b1;
               nxt.release_coil = 1'b0;
               nxt.mode = limit_switch ? dcbc_pkg::ST_ENGAGED : dcbc_pkg::ST_ENGAGING;
               rslt_num         = 2'd2;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      fin_rslt.apply_coil   = nxt.apply_coil;
      fin_rslt.release_coil = nxt.release_coil;
      fin_rslt.brake_state  = nxt.mode;
      fin_rslt.manual_mode  = nxt.manual;
      fin_rslt.hold_time    = 8'd0;
      fin_rslt.last         = 1'b1;
   end

   assign rslt_a = (rslt_num == 2'd2) ? dead_rslt : fin_rslt;
   assign rslt_b = fin_rslt;

endmodule

@@ src/dcbc_queue.sv @@
// Result queue: takes up to two results a cycle, hands out one a cycle.
// Depends on dcbc_pkg and the assertion macro header.
`include "dual_coil_brake_controller_assert.svh"

module dcbc_queue (
   input  logic               clock,
   input  logic               reset,
   input  dcbc_pkg::rslt_type push_a,
   input  dcbc_pkg::rslt_type push_b,
   input  logic [1:0]         push_num,
   output logic               room_ff_ok,
   input  logic               pop,
   output logic               head_valid,
   output dcbc_pkg::rslt_type head
);

   localparam int DEPTH = dcbc_pkg::RSLT_DEPTH;
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   dcbc_pkg::rslt_type entry_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               pop_ok;

   assign pop_ok     = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   // room for a two-result transaction, taken from registered count only
   assign room_ff_ok = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_num);
      rd_ptr_in = rd_ptr_ff + PW'(pop_ok);
      count_in  = count_ff + CW'(push_num) - CW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_num == 2'd2) begin
         entry_ff[wr_ptr_ff + PW'(1)] <= push_b;
      end
   end

   `DCBC_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(DEPTH))
   `DCBC_ASSERT_IMPL(a_no_overflow, push_num != 2'd0, room_ff_ok)
   `DCBC_ASSERT_NEXT(a_pop_drains, pop_ok && push_num == 2'd0, count_ff == $past(count_ff) - CW'(1))

endmodule

@@ src/dual_coil_brake_controller.sv @@
// Dual-coil brake controller, top level.
// Depends on dcbc_pkg, dcbc_core, dcbc_queue and the assertion macro header.
//
// Takes one command transaction per clock while req_tready is high. Brake
// state, manual flag and coil levels update in the accepting cycle; the
// command's results (none, one, or a dead-time result followed by the final
// one) go into a four-entry result queue and appear on rsp_ in the cycle
// after acceptance at the earliest. The response side drains one result per
// cycle while rsp_tready is high. req_tready is low while the queue has fewer
// than two free entries; it depends only on registered queue occupancy, never
// on rsp_tready. dead_time resets to 10 and is written through csr_wr_en.
`include "dual_coil_brake_controller_assert.svh"

module dual_coil_brake_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] cmd, [3] limit_switch, [7:4] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] apply_coil, [1] release_coil, [3:2] brake_state, [4] manual_mode,
   // [12:5] hold_time, [15:13] zero
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   dcbc_pkg::ctrl_state_type state_ff, state_in;
   dcbc_pkg::rslt_type       rslt_a, rslt_b, head;
   logic [1:0]               rslt_num, push_num;
   logic [7:0]               dead_time_ff;
   logic                     room_ok, accept;

   assign req_tready = room_ok;
   assign accept     = req_tvalid && req_tready;
   assign push_num   = accept ? rslt_num : 2'd0;

   dcbc_core u_core (
      .cmd          (req_tdata[2:0]),
      .limit_switch (req_tdata[3]),
      .dead_time    (dead_time_ff),
      .cur          (state_ff),
      .nxt          (state_in),
      .rslt_a       (rslt_a),
      .rslt_b       (rslt_b),
      .rslt_num     (rslt_num)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode         <= dcbc_pkg::ST_ENGAGING;
         state_ff.manual       <= 1'b0;
         state_ff.apply_coil   <= 1'b1;
         state_ff.release_coil <= 1'b0;
         dead_time_ff          <= dcbc_pkg::DEAD_TIME_RESET;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            dead_time_ff <= csr_wr_data;
         end
      end
   end

   dcbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_a     (rslt_a),
      .push_b     (rslt_b),
      .push_num   (push_num),
      .room_ff_ok (room_ok),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = {3'b000, head.hold_time, head.manual_mode, head.brake_state,
                       head.release_coil, head.apply_coil};
   assign rsp_tlast = head.last;

   `DCBC_ASSERT_IMPL(a_dead_result_coils_off, push_num == 2'd2, !rslt_a.apply_coil && !rslt_a.release_coil && !rslt_a.last && rslt_b.last)
   `DCBC_ASSERT_IMPL(a_manual_set_by_cmd, $rose(state_ff.manual), $past(accept) && ($past(req_tdata[2:0]) == dcbc_pkg::CMD_MAN_ENGAGE || $past(req_tdata[2:0]) == dcbc_pkg::CMD_MAN_RELEASE))
   `DCBC_ASSERT_ALWAYS(a_coils_exclusive, !(state_ff.apply_coil && state_ff.release_coil))

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dual_coil_brake_controller: directed and random
// command streams, with a built-in brake predictor checking every result.
// Depends on dcbc_pkg and the dual_coil_brake_controller RTL.
module tb;

   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int IDLE_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 271;
   localparam int NUM_PHASES = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [2:0] cmd, [3] limit_switch, [7:4] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] apply_coil, [1] release_coil, [3:2] brake_state, [4] manual_mode,
   // [12:5] hold_time, [15:13] zero
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;

   dual_coil_brake_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   logic [7:0]         pending_cmds[$];
   dcbc_pkg::rslt_type coil_results[$];
   int                 cmds_queued = 0;
   int                 cmds_taken = 0;
   int                 errors = 0;
   int                 idle_cycles = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;

   // predictor state
   logic [1:0] brake_mode = dcbc_pkg::ST_ENGAGING;
   logic       manual_on = 1'b0;
   logic       apply_on = 1'b1;
   logic       release_on = 1'b0;
   logic [7:0] dead_ms = dcbc_pkg::DEAD_TIME_RESET;

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      errors++;
   endtask

   function automatic void push_coil_result(input logic ap, input logic rel,
                                            input logic [7:0] hold, input logic fin);
      dcbc_pkg::rslt_type r;
      r.apply_coil   = ap;
      r.release_coil = rel;
      r.brake_state  = brake_mode;
      r.manual_mode  = manual_on;
      r.hold_time    = hold;
      r.last         = fin;
      coil_results.push_back(r);
   endfunction

   function automatic void predict_brake(input logic [2:0] cmd, input logic sw);
      case (cmd)
         dcbc_pkg::CMD_INIT: begin
            apply_on = 1'b1;
            release_on = 1'b0;
            brake_mode = sw ? dcbc_pkg::ST_ENGAGED : dcbc_pkg::ST_ENGAGING;
            push_coil_result(apply_on, release_on, 8'd0, 1'b1);
         end
         dcbc_pkg::CMD_ENGAGE: begin
            if (brake_mode != dcbc_pkg::ST_ENGAGED && brake_mode != dcbc_pkg::ST_ENGAGING) begin
               push_coil_result(1'b0, 1'b0, dead_ms, 1'b0);
               apply_on = 1'b1;
               release_on = 1'b0;
               brake_mode = dcbc_pkg::ST_ENGAGING;
               push_coil_result(apply_on, release_on, 8'd0, 1'b1);
            end
         end
         dcbc_pkg::CMD_RELEASE: begin
            if (brake_mode != dcbc_pkg::ST_RELEASED &&
                brake_mode != dcbc_pkg::ST_RELEASING) begin
               push_coil_result(1'b0, 1'b0, dead_ms, 1'b0);
               apply_on = 1'b0;
               release_on = 1'b1;
               brake_mode = dcbc_pkg::ST_RELEASING;
               push_coil_result(apply_on, release_on, 8'd0, 1'b1);
            end
         end
         dcbc_pkg::CMD_UPDATE: begin
            if (!manual_on) begin
               if (brake_mode == dcbc_pkg::ST_ENGAGING && sw)
                  brake_mode = dcbc_pkg::ST_ENGAGED;
               if (brake_mode == dcbc_pkg::ST_RELEASING && !sw) begin
                  release_on = 1'b0;
                  brake_mode = dcbc_pkg::ST_RELEASED;
               end
               // switch contradicts a released brake
               if (brake_mode == dcbc_pkg::ST_RELEASED && sw)
                  brake_mode = dcbc_pkg::ST_ENGAGED;
               push_coil_result(apply_on, release_on, 8'd0, 1'b1);
            end
         end
         dcbc_pkg::CMD_MAN_ENGAGE: begin
            manual_on = 1'b1;
            apply_on = 1'b1;
            release_on = 1'b0;
            push_coil_result(apply_on, release_on, 8'd0, 1'b1);
         end
         dcbc_pkg::CMD_MAN_RELEASE: begin
            manual_on = 1'b1;
            apply_on = 1'b0;
            release_on = 1'b1;
            push_coil_result(apply_on, release_on, 8'd0, 1'b1);
         end
         dcbc_pkg::CMD_MAN_STOP: begin
            if (manual_on) begin
               push_coil_result(1'b0, 1'b0, dead_ms, 1'b0);
               apply_on = 1'b1;
               release_on = 1'b0;
               brake_mode = sw ? dcbc_pkg::ST_ENGAGED : dcbc_pkg::ST_ENGAGING;
               manual_on = 1'b0;
               push_coil_result(apply_on, release_on, 8'd0, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] random_cmd();
      int unsigned pick;
      logic [2:0]  cmd;
      pick = $urandom_range(99);
      if (pick < 8)       cmd = dcbc_pkg::CMD_INIT;
      else if (pick < 24) cmd = dcbc_pkg::CMD_ENGAGE;
      else if (pick < 40) cmd = dcbc_pkg::CMD_RELEASE;
      else if (pick < 68) cmd = dcbc_pkg::CMD_UPDATE;
      else if (pick < 78) cmd = dcbc_pkg::CMD_MAN_ENGAGE;
      else if (pick < 86) cmd = dcbc_pkg::CMD_MAN_RELEASE;
      else if (pick < 97) cmd = dcbc_pkg::CMD_MAN_STOP;
      else                cmd = CMD_UNUSED;
      return {4'b0, 1'($urandom_range(1)), cmd};
   endfunction

   task automatic queue_cmd(input logic [2:0] cmd, input logic sw);
      pending_cmds.push_back({4'b0, sw, cmd});
      cmds_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (cmds_taken != cmds_queued || coil_results.size() != 0);
      // ignored commands give no result, so allow for work still in flight
      repeat (8) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_cmds.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin : monitor_blk
      dcbc_pkg::rslt_type want;
      logic               busy;
      busy = 1'b0;
      if (!reset) begin
         if (csr_wr_en)
            dead_ms = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            busy = 1'b1;
            if (coil_results.size() == 0) begin
               report_mismatch("unexpected result", 0, rsp_tdata);
            end else begin
               want = coil_results.pop_front();
               if (rsp_tdata[0] !== want.apply_coil)
                  report_mismatch("apply_coil", want.apply_coil, rsp_tdata[0]);
               if (rsp_tdata[1] !== want.release_coil)
                  report_mismatch("release_coil", want.release_coil, rsp_tdata[1]);
               if (rsp_tdata[3:2] !== want.brake_state)
                  report_mismatch("brake_state", want.brake_state, rsp_tdata[3:2]);
               if (rsp_tdata[4] !== want.manual_mode)
                  report_mismatch("manual_mode", want.manual_mode, rsp_tdata[4]);
               if (rsp_tdata[12:5] !== want.hold_time)
                  report_mismatch("hold_time", want.hold_time, rsp_tdata[12:5]);
               if (rsp_tdata[15:13] !== 3'b000)
                  report_mismatch("tdata padding", 0, rsp_tdata[15:13]);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", want.last, rsp_tlast);
            end
         end
         // predict after checking, so a transaction is never matched to itself
         if (req_tvalid && req_tready) begin
            busy = 1'b1;
            cmds_taken++;
            predict_brake(req_tdata[2:0], req_tdata[3]);
         end
         idle_cycles = busy ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] dead_setting;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk through the brake states, dead time at its reset value
      queue_cmd(dcbc_pkg::CMD_INIT, 1'b0);
      queue_cmd(dcbc_pkg::CMD_ENGAGE, 1'b0);         // already engaging
      queue_cmd(dcbc_pkg::CMD_UPDATE, 1'b1);         // engaging -> engaged
      queue_cmd(dcbc_pkg::CMD_RELEASE, 1'b1);
      queue_cmd(dcbc_pkg::CMD_RELEASE, 1'b0);        // already releasing
      queue_cmd(dcbc_pkg::CMD_UPDATE, 1'b1);         // still moving
      queue_cmd(dcbc_pkg::CMD_UPDATE, 1'b0);         // releasing -> released
      queue_cmd(dcbc_pkg::CMD_UPDATE, 1'b1);         // released but switch closed
      queue_cmd(dcbc_pkg::CMD_RELEASE, 1'b0);
      queue_cmd(dcbc_pkg::CMD_UPDATE, 1'b0);
      queue_cmd(dcbc_pkg::CMD_ENGAGE, 1'b0);         // from released
      queue_cmd(dcbc_pkg::CMD_RELEASE, 1'b1);
      queue_cmd(dcbc_pkg::CMD_ENGAGE, 1'b1);         // from releasing
      queue_cmd(dcbc_pkg::CMD_MAN_STOP, 1'b1);       // not in manual mode
      queue_cmd(dcbc_pkg::CMD_MAN_ENGAGE, 1'b0);
      queue_cmd(dcbc_pkg::CMD_UPDATE, 1'b1);         // suppressed in manual mode
      queue_cmd(dcbc_pkg::CMD_MAN_RELEASE, 1'b1);
      queue_cmd(dcbc_pkg::CMD_RELEASE, 1'b0);        // automatic commands act in manual
      queue_cmd(dcbc_pkg::CMD_ENGAGE, 1'b1);
      queue_cmd(dcbc_pkg::CMD_MAN_STOP, 1'b1);
      queue_cmd(dcbc_pkg::CMD_MAN_RELEASE, 1'b0);
      queue_cmd(dcbc_pkg::CMD_MAN_STOP, 1'b0);
      queue_cmd(CMD_UNUSED, 1'b1);
      queue_cmd(dcbc_pkg::CMD_INIT, 1'b1);
      queue_cmd(dcbc_pkg::CMD_UPDATE, 1'b0);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1:       dead_setting = 8'd0;
               2:       dead_setting = 8'd255;
               4:       dead_setting = 8'd1;
               default: dead_setting = 8'($urandom_range(254, 2));
            endcase
            csr_wr_en   <= 1'b1;
            csr_wr_data <= dead_setting;
            @(posedge clock);
            csr_wr_en   <= 1'b0;
            @(negedge clock);
         end
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pending_cmds.push_back(random_cmd());
            cmds_queued++;
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (coil_results.size() != 0)
         report_mismatch("results still outstanding", 0, coil_results.size());
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
